>>> design/rfgl_pkg.sv
// Package for the RMS frame gain leveler: payload types, sequencer states and fixed constants.
package rfgl_pkg;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last;
		logic               muted;
	} rfgl_in_t;

	typedef struct packed {
		logic [16:0] new_gain;
		logic [16:0] frame_level;
		logic        adjusted;
	} rfgl_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_SQRT,
		ST_MUL,
		ST_STEP,
		ST_EMIT
	} rfgl_state_t;

	localparam logic [1:0] CFG_TARGET = 2'd0;
	localparam logic [1:0] CFG_FLOOR  = 2'd1;
	localparam logic [1:0] CFG_STEP   = 2'd2;

	localparam logic [16:0] UNITY_GAIN = 17'd65536;
	localparam logic [16:0] RST_TARGET = 17'd1165;
	localparam logic [16:0] RST_FLOOR  = 17'd207;
	localparam logic [16:0] RST_STEP   = 17'd3277;

	// A square of a Q1.15 sample is at most 2^30, and so is the mean.
	localparam int SQ_W       = 31;
	localparam int MEAN_W     = 31;
	// Square root of 4 * mean: 34-bit radicand, 17-bit root.
	localparam int RAD_W      = 34;
	localparam int ROOT_W     = 17;
	localparam int SQRT_STEPS = 17;
	localparam int PROD_W     = 34;

	function automatic logic [16:0] sat_unity(input logic [16:0] v);
		return (v > UNITY_GAIN) ? UNITY_GAIN : v;
	endfunction

endpackage

>>> design/rms_frame_gain_leveler.sv
// Top level of the RMS frame gain leveler: accumulator, shared divide and square root unit, gain step.
//
// Samples arrive on the smp channel (smp_valid, smp_stall, smp_data); a transfer happens on a
// rising edge with smp_valid high and smp_stall low. Each sample is taken in and squared
// in the idle state, and its square is added to the frame sum in the accumulate state.
// A sample with last set closes the frame, and the block then works out the frame's RMS
// level and new gain before it takes another sample: a restoring divide of the SUM_W-bit
// square sum (41 bits at the default MAX_FRAME_SAMPLES) at one quotient bit per cycle and
// a square root at one root bit per cycle, both run on the same subtractor, then a multiply,
// a gain step and the result load. Muted or empty frames skip the later steps, and frames
// below the detect floor skip the gain step.
// One result transfer on the res channel follows each frame. The result sits in an output
// register; if the receiver holds res_stall high the block still takes the samples of the
// next frame and only waits when that frame's result is ready to be loaded.
// Configuration writes on the cfg channel are always taken (cfg_ready is high) and should
// only be made while the block is idle. Values above 1.0 saturate to 1.0.
// Reset (arst_n low) restores the default registers, unity gain and an empty frame.
module rms_frame_gain_leveler
	import rfgl_pkg::*;
#(
	parameter int MAX_FRAME_SAMPLES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        smp_valid,
	output logic        smp_stall,
	input  rfgl_in_t    smp_data,
	output logic        res_valid,
	input  logic        res_stall,
	output rfgl_out_t   res_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	// The tally must be able to hold the frame limit itself, and the sum that many maximal
	// squares.
	localparam int TALLY_W = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int SUM_W   = SQ_W - 1 + TALLY_W;
	// The subtractor serves both the divide remainder and the square root remainder.
	localparam int SUB_W   = (TALLY_W + 1 > 20) ? TALLY_W + 1 : 20;
	localparam int CNT_W   = $clog2(SUM_W + 1);
	localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(MAX_FRAME_SAMPLES);
	localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(SUM_W - 1);
	localparam logic [CNT_W-1:0]   SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

	rfgl_state_t          state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     sum_q;
	logic [TALLY_W-1:0]   tally_q;
	logic [16:0]          gain_q, target_q, floor_q, step_q;
	logic                 res_valid_q;

	logic [SQ_W-1:0]      sq_q;
	logic                 last_q, muted_q;
	logic [SUB_W-1:0]     rem_q;
	logic [RAD_W-1:0]     rad_q;
	logic [ROOT_W-1:0]    root_q;
	logic [PROD_W-1:0]    prod_q;
	logic [16:0]          level_q;
	logic                 adj_q;
	rfgl_out_t            res_data_q;

	logic signed [31:0]   sq_full;
	logic                 take;
	logic [TALLY_W-1:0]   tally_nx;
	logic [SUM_W-1:0]     sum_nx;
	logic [SUB_W-1:0]     sub_a, sub_b;
	logic [SUB_W:0]       sub_diff;
	logic                 sub_ge;
	logic [SUM_W-1:0]     quot_nx;
	logic [32:0]          goal;
	logic                 too_quiet;
	logic signed [18:0]   gain_x;
	logic [16:0]          gain_new;
	logic                 emit_load;

	// Squaring happens as the sample is taken in; the product of two Q1.15 values never
	// exceeds 2^30, so 31 bits hold it.
	assign sq_full = 32'(smp_data.sample) * 32'(smp_data.sample);

	// Samples beyond the frame limit are neither summed nor counted.
	assign take     = (tally_q < TALLY_MAX);
	assign tally_nx = take ? tally_q + 1'b1 : tally_q;
	assign sum_nx   = take ? sum_q + SUM_W'(sq_q) : sum_q;

	// The one shared subtractor. In the divide it tries the divisor against the shifted
	// remainder; in the square root it tries 4 * root + 1 against the remainder with the
	// next two radicand bits brought in.
	always_comb begin
		if (state_q == ST_SQRT) begin
			sub_a = {rem_q[SUB_W-3:0], rad_q[RAD_W-1 -: 2]};
			sub_b = SUB_W'({root_q, 2'b01});
		end else begin
			sub_a = SUB_W'({rem_q[TALLY_W-1:0], sum_q[SUM_W-1]});
			sub_b = SUB_W'(tally_q);
		end
	end

	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge   = ~sub_diff[SUB_W];
	// The dividend shifts out of the sum register while quotient bits shift in behind it.
	assign quot_nx  = {sum_q[SUM_W-2:0], sub_ge};

	// Gain step: too quiet means level * gain falls short of target * 1.0. The step may
	// take the gain below zero, hence the signed intermediate before the clamp.
	assign goal      = {target_q, 16'd0};
	assign too_quiet = (prod_q < {1'b0, goal});

	always_comb begin
		if (too_quiet) begin
			gain_x = $signed({2'b00, gain_q}) + $signed({2'b00, step_q});
		end else begin
			gain_x = $signed({2'b00, gain_q}) - $signed({2'b00, step_q});
		end
		if (gain_x < $signed({2'b00, floor_q})) begin
			gain_new = floor_q;
		end else if (gain_x > $signed({2'b00, UNITY_GAIN})) begin
			gain_new = UNITY_GAIN;
		end else begin
			gain_new = gain_x[16:0];
		end
	end

	// The result register may be reloaded once its previous content has been transferred
	// or is being transferred in this cycle.
	assign emit_load = (state_q == ST_EMIT) && (!res_valid_q || !res_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (smp_valid) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (!last_q) begin
					state_d = ST_IDLE;
				end else if (muted_q || (tally_nx == '0)) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (cnt_q == SQRT_LAST) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				// A level under the detect floor leaves the gain alone.
				if (root_q < floor_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign smp_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			tally_q     <= '0;
			gain_q      <= UNITY_GAIN;
			target_q    <= RST_TARGET;
			floor_q     <= RST_FLOOR;
			step_q      <= RST_STEP;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// The iteration counter restarts on every change of state.
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end

			if (state_q == ST_ACC) begin
				sum_q   <= sum_nx;
				tally_q <= tally_nx;
			end else if (state_q == ST_DIV) begin
				sum_q <= quot_nx;
			end else if (emit_load) begin
				sum_q   <= '0;
				tally_q <= '0;
			end

			if (state_q == ST_STEP) begin
				gain_q <= gain_new;
			end

			if (emit_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_TARGET: target_q <= sat_unity(cfg_data);
					CFG_FLOOR:  floor_q  <= sat_unity(cfg_data);
					CFG_STEP:   step_q   <= sat_unity(cfg_data);
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (smp_valid) begin
					sq_q    <= sq_full[SQ_W-1:0];
					last_q  <= smp_data.last;
					muted_q <= smp_data.muted;
				end
			end
			ST_ACC: begin
				rem_q   <= '0;
				level_q <= '0;
				adj_q   <= 1'b0;
			end
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					// Radicand is 4 * mean; the mean never exceeds 2^30.
					rad_q  <= {1'b0, quot_nx[MEAN_W-1:0], 2'b00};
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					rem_q <= sub_ge ? sub_diff[SUB_W-1:0] : sub_a;
				end
			end
			ST_SQRT: begin
				rem_q  <= sub_ge ? sub_diff[SUB_W-1:0] : sub_a;
				root_q <= {root_q[ROOT_W-2:0], sub_ge};
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			end
			ST_MUL: begin
				level_q <= root_q;
				prod_q  <= PROD_W'(root_q) * PROD_W'(gain_q);
				adj_q   <= 1'b0;
			end
			ST_STEP: begin
				// A step counts as an adjustment even when the clamp keeps the old gain.
				adj_q <= 1'b1;
			end
			ST_EMIT: begin
				if (emit_load) begin
					res_data_q.new_gain    <= gain_q;
					res_data_q.frame_level <= level_q;
					res_data_q.adjusted    <= adj_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	// A result only appears after the sequencer has been through its load state.
	a_res_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside the load state");

	// The clamp keeps the gain at or below unity.
	a_gain_max: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= UNITY_GAIN)
		else $error("gain above unity");

	// The sample count never passes the frame limit.
	a_tally_max: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q <= TALLY_MAX)
		else $error("sample count beyond frame limit");

	// A frame's work never overwrites a result that is still waiting to be transferred.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res_data)))
		else $error("waiting result lost or changed");
`endif

endmodule

>>> tb/sv/rms_frame_gain_leveler_tb.sv
// Self-checking testbench for the RMS frame gain leveler: predicted frame gains against the block.
`timescale 1ns / 100ps

module rms_frame_gain_leveler_tb;
	import rfgl_pkg::*;

	// The spare register index decodes to nothing; writes to it must leave every register alone.
	localparam logic [1:0] CFG_SPARE = 2'd3;

	localparam int FRAME_CAP       = 1024;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 10;
	// The guard is rounded up well past the work that follows a closing sample.
	localparam int SETTLE_CYCLES   = 100;
	localparam int RUN_LIMIT_NS    = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        smp_valid = 1'b0;
	logic        smp_stall;
	rfgl_in_t    smp_data = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	rfgl_out_t   res_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_TARGET;
	logic [16:0] cfg_data = '0;

	// Samples waiting to be offered, and the frame reports the block still owes us.
	rfgl_in_t  sample_backlog[$];
	rfgl_out_t due_reports[$];

	// Our own copy of the block's registers and frame state.
	logic [16:0] level_target;
	logic [16:0] level_floor;
	logic [16:0] level_step;
	logic [16:0] tracked_gain;
	longint      frame_energy;
	int          frame_count;

	// Transfer flags, captured at the rising edge and acted upon at the following falling edge.
	logic smp_took = 1'b0;
	logic res_took = 1'b0;
	logic cfg_took = 1'b0;

	// Idle patterns for either side: bursts of random waits interleaved with stretches of none.
	int smp_wait = 0;
	int smp_sent = 0;
	bit smp_busy = 1'b1;
	int res_wait = 0;
	int res_seen = 0;
	bit res_busy = 1'b1;

	int fault_count = 0;

	rms_frame_gain_leveler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp_data  (smp_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Largest integer r with r * r no greater than v; v never exceeds 2^32 here, so the root
	// fits in 17 bits.
	function automatic longint root_floor(input longint v);
		longint r;
		longint t;
		r = 0;
		for (int b = 17; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// Register writes saturate at 1.0, exactly as the block does on its side.
	function automatic logic [16:0] clip_unity(input logic [16:0] v);
		return (v > UNITY_GAIN) ? UNITY_GAIN : v;
	endfunction

	// Folds one accepted sample into the frame. When the sample closes the frame, the
	// level and the gain step are worked out and the resulting report is queued.
	task automatic absorb_sample(input rfgl_in_t item);
		longint     sv;
		longint     mean;
		longint     lvl;
		longint     x;
		rfgl_out_t  rep;
		sv = longint'(item.sample);
		// Once the frame is full, further samples of it are dropped, the closing one too.
		if (frame_count < FRAME_CAP) begin
			frame_energy += sv * sv;
			frame_count++;
		end
		if (item.last) begin
			lvl = 0;
			rep.adjusted = 1'b0;
			// A muted frame reports level 0 and leaves the gain as it is; an empty frame
			// cannot happen, but is guarded the same way.
			if (!item.muted && frame_count != 0) begin
				mean = frame_energy / frame_count;
				lvl = root_floor(mean * 4);
				if (lvl > longint'(UNITY_GAIN))
					lvl = longint'(UNITY_GAIN);
				// Below the detect floor the gain is held.
				if (lvl >= longint'(level_floor)) begin
					if (lvl * longint'(tracked_gain) < (longint'(level_target) << 16))
						x = longint'(tracked_gain) + longint'(level_step);
					else
						x = longint'(tracked_gain) - longint'(level_step);
					// A step counts as an adjustment even if the clamp undoes it.
					if (x < longint'(level_floor))
						x = longint'(level_floor);
					else if (x > longint'(UNITY_GAIN))
						x = longint'(UNITY_GAIN);
					tracked_gain = x[16:0];
					rep.adjusted = 1'b1;
				end
			end
			rep.new_gain = tracked_gain;
			rep.frame_level = lvl[16:0];
			due_reports.push_back(rep);
			frame_energy = 0;
			frame_count = 0;
		end
	endtask

	// Everything that happens at the rising edge: transfers are recognised, the predictor is
	// advanced, and each result transfer is compared with the oldest report owed.
	always @(posedge clk) begin
		rfgl_out_t want;
		smp_took <= smp_valid && !smp_stall;
		res_took <= res_valid && !res_stall;
		cfg_took <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TARGET: level_target = clip_unity(cfg_data);
					CFG_FLOOR:  level_floor = clip_unity(cfg_data);
					CFG_STEP:   level_step = clip_unity(cfg_data);
					default:    ;
				endcase
			end
			if (smp_valid && !smp_stall)
				absorb_sample(smp_data);
			if (res_valid && !res_stall) begin
				if (due_reports.size() == 0) begin
					$error("res_data: result transfer with no report pending");
					fault_count++;
				end else begin
					want = due_reports.pop_front();
					if (res_data.new_gain !== want.new_gain) begin
						$error("new_gain: expected %0d, got %0d", want.new_gain,
							res_data.new_gain);
						fault_count++;
					end
					if (res_data.frame_level !== want.frame_level) begin
						$error("frame_level: expected %0d, got %0d", want.frame_level,
							res_data.frame_level);
						fault_count++;
					end
					if (res_data.adjusted !== want.adjusted) begin
						$error("adjusted: expected %0d, got %0d", want.adjusted,
							res_data.adjusted);
						fault_count++;
					end
				end
			end
		end
	end

	// Sample driver. A new sample is only offered once the previous one has gone through a
	// transfer and its wait has run out; while stalled the payload is held as it is.
	always @(negedge clk) begin
		if (arst_n && (!smp_valid || smp_took)) begin
			if (smp_wait > 0) begin
				smp_wait--;
				smp_valid <= 1'b0;
			end else if (sample_backlog.size() != 0) begin
				smp_data <= sample_backlog.pop_front();
				smp_valid <= 1'b1;
				smp_sent++;
				if (smp_sent % 32 == 0)
					smp_busy = ($urandom_range(0, 3) != 0);
				smp_wait = smp_busy ? $urandom_range(0, 15) : 0;
			end else begin
				smp_valid <= 1'b0;
			end
		end
	end

	// Result receiver. After every result transfer it draws how long to hold stall high.
	always @(negedge clk) begin
		if (res_took) begin
			res_seen++;
			if (res_seen % 8 == 0)
				res_busy = ($urandom_range(0, 3) != 0);
			res_wait = res_busy ? $urandom_range(0, 15) : 0;
		end
		if (res_wait > 0) begin
			res_wait--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	task automatic push_sample(input logic signed [15:0] s, input logic lst, input logic mut);
		rfgl_in_t item;
		item.sample = s;
		item.last = lst;
		item.muted = mut;
		sample_backlog.push_back(item);
	endtask

	// Queues one frame of len samples. The loudness style sets the spread of the samples:
	// around the floor, around the target, or anywhere in the full range.
	task automatic queue_frame(input int len, input int style, input bit mute_close);
		int amp;
		int v;
		case (style)
			0:       amp = $urandom_range(0, 400);
			1:       amp = $urandom_range(400, 4000);
			2:       amp = $urandom_range(0, 32767);
			default: amp = -1;
		endcase
		for (int i = 0; i < len; i++) begin
			if (amp < 0)
				v = $urandom_range(0, 65535);
			else
				v = int'($urandom_range(0, 2 * amp)) - amp;
			// The muted flag on inner samples is noise that the block has to ignore.
			if (i == len - 1)
				push_sample(v[15:0], 1'b1, mute_close);
			else
				push_sample(v[15:0], 1'b0, 1'($urandom_range(0, 1)));
		end
	endtask

	// Mostly ordinary values, with the extremes and over-range writes mixed in.
	function automatic logic [16:0] pick_setting(input int typical_hi);
		case ($urandom_range(0, 9))
			0:       return 17'd0;
			1:       return 17'd1;
			2:       return UNITY_GAIN;
			3:       return 17'h1FFFF;
			4:       return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, typical_hi));
		endcase
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(negedge clk);
		while (!cfg_took);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_settings(input int ph);
		logic [16:0] t;
		logic [16:0] f;
		logic [16:0] g;
		logic [16:0] spare;
		case (ph)
			1: begin
				t = 17'd0;
				f = 17'd0;
				g = 17'd0;
			end
			2: begin
				t = UNITY_GAIN;
				f = 17'h1FFFF;
				g = UNITY_GAIN;
			end
			3: begin
				t = 17'h1FFFF;
				f = 17'd1;
				g = 17'd1;
			end
			default: begin
				t = pick_setting(20000);
				f = pick_setting(1500);
				g = pick_setting(8000);
			end
		endcase
		write_reg(CFG_TARGET, t);
		write_reg(CFG_FLOOR, f);
		write_reg(CFG_STEP, g);
		spare = 17'($urandom());
		write_reg(CFG_SPARE, spare);
	endtask

	// Waits until every sample has gone through a transfer and every report has arrived, then
	// lets the block's closing latency pass so that nothing is left in flight.
	task automatic settle();
		while (sample_backlog.size() != 0 || smp_valid || due_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int queued;
		int len;
		level_target = RST_TARGET;
		level_floor = RST_FLOOR;
		level_step = RST_STEP;
		tracked_gain = UNITY_GAIN;
		frame_energy = 0;
		frame_count = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames under the reset settings. A quiet frame first, so that the first
		// step is upwards from unity and the clamp leaves the gain unchanged.
		push_sample(16'sd104, 1'b0, 1'b0);
		push_sample(16'sd104, 1'b1, 1'b0);
		// Just below the floor: the gain is held.
		push_sample(16'sd100, 1'b1, 1'b0);
		// Full scale at either end of the sample range.
		push_sample(-16'sd32768, 1'b1, 1'b0);
		push_sample(16'sd32767, 1'b0, 1'b0);
		push_sample(-16'sd32768, 1'b0, 1'b1);
		push_sample(16'sd32767, 1'b1, 1'b0);
		// Silence and the smallest non-zero levels.
		push_sample(16'sd0, 1'b1, 1'b0);
		push_sample(-16'sd1, 1'b1, 1'b0);
		push_sample(16'sd1, 1'b1, 1'b0);
		// Muted frames report level 0 however loud they are.
		push_sample(16'sd1, 1'b0, 1'b0);
		push_sample(-16'sd32768, 1'b1, 1'b1);
		push_sample(-16'sd32768, 1'b1, 1'b1);
		// Levels either side of the target, so that the gain moves both ways.
		push_sample(16'sd1000, 1'b0, 1'b0);
		push_sample(-16'sd1000, 1'b1, 1'b0);
		push_sample(16'sd600, 1'b1, 1'b0);
		push_sample(-16'sd560, 1'b1, 1'b0);
		settle();

		// Random phases, each under its own register settings.
		for (int ph = 1; ph <= PHASES; ph++) begin
			load_settings(ph);
			queued = 0;
			while (queued < ITEMS_PER_PHASE) begin
				len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
				queue_frame(len, $urandom_range(0, 3), $urandom_range(0, 7) == 0);
				queued += len;
			end
			settle();
		end

		// A frame that runs past the sample cap under the reset settings: the samples beyond
		// the cap, the closing one among them, must leave the sum and the count alone.
		write_reg(CFG_TARGET, RST_TARGET);
		write_reg(CFG_FLOOR, RST_FLOOR);
		write_reg(CFG_STEP, RST_STEP);
		queue_frame(FRAME_CAP + 2, 3, 1'b0);
		queue_frame(3, 2, 1'b0);
		settle();

		if (due_reports.size() != 0) begin
			$error("due_reports: %0d reports never arrived", due_reports.size());
			fault_count++;
		end
		if (fault_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog against a block that hangs on a handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule
